@@ hdl/flstat_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// flstat_pkg
// Shared types and constants for the frame-present latency monitor.
// ----------------------------------------------------------------------------
package flstat_pkg;

    // Window geometry.
    localparam int WINDOW_DEPTH = 256;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

    // Percentile register.
    localparam int              PCT_W     = 7;
    localparam logic [PCT_W-1:0] PCT_RESET = 7'd95;
    localparam int              PCT_SCALE = 100;

    // Rank = floor(fill * pct / 100), done as a multiply by a rounded-up reciprocal.
    localparam int PROD_W      = FILL_W + PCT_W;
    localparam int RECIP_SHIFT = PROD_W + 7;
    localparam int RECIP_W     = RECIP_SHIFT - 6;
    localparam int RECIP_INT   = (1 << RECIP_SHIFT) / PCT_SCALE + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_INT);
    localparam int MUL_W       = PROD_W + RECIP_W;
    localparam int QUO_W       = FILL_W + 1;

    // Request opcodes.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_BEGIN  = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] start_time_us;
        logic [63:0] blit_done_time_us;
        logic [63:0] swap_done_time_us;
        logic        carries_video;
    } t_req;

    typedef struct packed {
        logic [63:0] present_total;
        logic [63:0] video_present_total;
        logic [63:0] blit_sum_us;
        logic [63:0] blit_peak_us;
        logic [63:0] swap_sum_us;
        logic [63:0] blit_percentile_us;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_RANK,
        S_DIV,
        S_CAND,
        S_CWAIT,
        S_SCAN,
        S_CHECK
    } t_state;

endpackage : flstat_pkg
`default_nettype wire

@@ hdl/frame_latency_stats_p95.sv @@
`default_nettype none
// A sample request is staged when taken and written back in the next cycle, so busy
// stays high for one cycle after it. Begin, unused and disarmed end requests leave busy
// low. An end request while armed searches the ring by rank counting through its single
// read port (skipped when the ring is empty), then raises one result strobe as busy falls.
// The receiver cannot stall.
// Synchronous active-low reset disarms and clears all counters; the ring is never cleared.
// ----------------------------------------------------------------------------
// frame_latency_stats_p95
// Frame-present latency monitor with blit and swap totals, a blit peak and a
// percentile blit time over a ring of the most recent samples.
// ----------------------------------------------------------------------------
module frame_latency_stats_p95
    import flstat_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_req             i_req,
    input  wire logic             i_cfg_we,
    input  wire logic [PCT_W-1:0] i_cfg_wdata,
    output logic                  o_result_vld,
    output t_result               o_result
);

    // State registers.
    t_state              r_state, n_state;
    logic                r_armed;
    logic [PCT_W-1:0]    r_pct;
    logic [FILL_W-1:0]   r_fill;
    logic [ADDR_W-1:0]   r_wr_ptr;
    logic [63:0]         r_present_cnt;
    logic [63:0]         r_video_cnt;
    logic [63:0]         r_blit_acc;
    logic [63:0]         r_swap_acc;
    logic [63:0]         r_blit_max;

    // Sample staging registers.
    logic [63:0]         r_blit;
    logic [63:0]         r_swap;
    logic                r_ord;
    logic                r_vid;

    // Percentile search registers.
    logic [PROD_W-1:0]   r_prod;
    logic [FILL_W-1:0]   r_rank;
    logic [ADDR_W-1:0]   r_cidx;
    logic [63:0]         r_cval;
    logic [FILL_W-1:0]   r_scan;
    logic                r_dv;
    logic [FILL_W-1:0]   r_less;
    logic [FILL_W-1:0]   r_eq;

    // Output register.
    logic                r_out_vld;
    t_result             r_out;

    // Window memory.
    logic [63:0]         r_mem [WINDOW_DEPTH];
    logic [63:0]         r_rd_data;

    logic                w_accept;
    logic [64:0]         w_blit_ext;
    logic [64:0]         w_swap_ext;
    logic [MUL_W-1:0]    w_mul;
    logic [QUO_W-1:0]    w_quo;
    logic [FILL_W-1:0]   w_rank;
    logic [QUO_W-1:0]    w_upper;
    logic                w_issue;
    logic                w_found;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic                w_sample_ok;

    assign busy         = (r_state != S_IDLE);
    assign w_accept     = start && !busy;
    assign o_result_vld = r_out_vld;
    assign o_result     = r_out;

    // Durations with borrow; a clear borrow means the timestamps are ordered.
    assign w_blit_ext = {1'b0, i_req.blit_done_time_us} - {1'b0, i_req.start_time_us};
    assign w_swap_ext = {1'b0, i_req.swap_done_time_us} - {1'b0, i_req.blit_done_time_us};

    // Rank by reciprocal multiply, clamped to the last stored sample.
    assign w_mul   = MUL_W'(r_prod) * MUL_W'(RECIP);
    assign w_quo   = w_mul[RECIP_SHIFT +: QUO_W];
    assign w_rank  = (w_quo >= {1'b0, r_fill}) ? (r_fill - 1'b1) : w_quo[FILL_W-1:0];

    // Search control: the candidate sits at the rank when the rank falls in its tie span.
    assign w_issue = (r_scan < r_fill);
    assign w_upper = {1'b0, r_less} + {1'b0, r_eq};
    assign w_found = (r_less <= r_rank) && ({1'b0, r_rank} < w_upper);

    assign w_sample_ok = r_armed && r_ord;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_req.opcode == OP_SAMPLE)) begin
                    n_state = S_UPD;
                end else if (w_accept && (i_req.opcode == OP_END) && r_armed) begin
                    n_state = S_RANK;
                end
            end
            S_UPD:   n_state = S_IDLE;
            S_RANK:  n_state = (r_fill == '0) ? S_IDLE : S_DIV;
            S_DIV:   n_state = S_CAND;
            S_CAND:  n_state = S_CWAIT;
            S_CWAIT: n_state = S_SCAN;
            S_SCAN:  n_state = w_issue ? S_SCAN : S_CHECK;
            S_CHECK: n_state = w_found ? S_IDLE : S_CAND;
            default: n_state = S_IDLE;
        endcase
    end

    // Memory read address: the candidate, or the element under scan.
    always_comb begin
        case (r_state)
            S_CAND:  w_rd_addr = r_cidx;
            default: w_rd_addr = r_scan[ADDR_W-1:0];
        endcase
    end

    // Window memory, one write and one registered read. Writes happen only in the
    // update state and read data is used only during the search, so the two never overlap.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_UPD) && w_sample_ok) begin
            r_mem[r_wr_ptr] <= r_blit;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Control state, statistics and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_armed       <= 1'b0;
            r_pct         <= PCT_RESET;
            r_fill        <= '0;
            r_wr_ptr      <= '0;
            r_present_cnt <= '0;
            r_video_cnt   <= '0;
            r_blit_acc    <= '0;
            r_swap_acc    <= '0;
            r_blit_max    <= '0;
            r_out_vld     <= 1'b0;
            r_dv          <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= 1'b0;

            if (i_cfg_we) begin
                r_pct <= i_cfg_wdata;
            end

            // Begin clears every statistic and arms; end disarms.
            if (w_accept && (i_req.opcode == OP_BEGIN)) begin
                r_armed       <= 1'b1;
                r_fill        <= '0;
                r_wr_ptr      <= '0;
                r_present_cnt <= '0;
                r_video_cnt   <= '0;
                r_blit_acc    <= '0;
                r_swap_acc    <= '0;
                r_blit_max    <= '0;
            end else if (w_accept && (i_req.opcode == OP_END)) begin
                r_armed <= 1'b0;
            end

            // Accepted sample: update totals and advance the ring pointer.
            if ((r_state == S_UPD) && w_sample_ok) begin
                r_present_cnt <= r_present_cnt + 64'd1;
                r_video_cnt   <= r_video_cnt + {63'd0, r_vid};
                r_blit_acc    <= r_blit_acc + r_blit;
                r_swap_acc    <= r_swap_acc + r_swap;
                if (r_blit > r_blit_max) begin
                    r_blit_max <= r_blit;
                end
                if (r_fill < FILL_W'(WINDOW_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
                if (r_wr_ptr == ADDR_W'(WINDOW_DEPTH - 1)) begin
                    r_wr_ptr <= '0;
                end else begin
                    r_wr_ptr <= r_wr_ptr + 1'b1;
                end
            end

            // Scan read pipeline valid flag.
            if (r_state == S_SCAN) begin
                r_dv <= w_issue;
            end else begin
                r_dv <= 1'b0;
            end

            // Result strobe for an empty window or a found rank.
            if ((r_state == S_RANK) && (r_fill == '0)) begin
                r_out_vld <= 1'b1;
            end else if ((r_state == S_CHECK) && w_found) begin
                r_out_vld <= 1'b1;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        // Stage the durations of an incoming request.
        if (w_accept) begin
            r_blit <= w_blit_ext[63:0];
            r_swap <= w_swap_ext[63:0];
            r_ord  <= !w_blit_ext[64] && !w_swap_ext[64];
            r_vid  <= i_req.carries_video;
        end

        case (r_state)
            S_RANK: begin
                r_prod <= PROD_W'(r_fill) * PROD_W'(r_pct);
                r_out.present_total       <= r_present_cnt;
                r_out.video_present_total <= r_video_cnt;
                r_out.blit_sum_us         <= r_blit_acc;
                r_out.blit_peak_us        <= r_blit_max;
                r_out.swap_sum_us         <= r_swap_acc;
                r_out.blit_percentile_us  <= '0;
            end
            S_DIV: begin
                r_rank <= w_rank;
                r_cidx <= '0;
            end
            S_CWAIT: begin
                r_cval <= r_rd_data;
                r_scan <= '0;
                r_less <= '0;
                r_eq   <= '0;
            end
            S_SCAN: begin
                if (w_issue) begin
                    r_scan <= r_scan + 1'b1;
                end
                if (r_dv) begin
                    if (r_rd_data < r_cval) begin
                        r_less <= r_less + 1'b1;
                    end else if (r_rd_data == r_cval) begin
                        r_eq <= r_eq + 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (w_found) begin
                    r_out.blit_percentile_us <= r_cval;
                end else begin
                    r_cidx <= r_cidx + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTH
    // A report is only produced after the monitor has been disarmed.
    a_result_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_vld |-> !r_armed)
        else $error("result strobe while the monitor is armed");

    // The fill count never passes the window depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW_DEPTH))
        else $error("window fill above depth");

    // A begin request leaves the monitor armed with an empty window.
    a_begin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.opcode == OP_BEGIN)) |=> (r_armed && (r_fill == '0)))
        else $error("begin did not clear and arm");

    // During the scan, the search candidate lies within the written part of the ring.
    a_cand_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_cidx} < r_fill))
        else $error("search candidate beyond stored samples");
`endif

endmodule : frame_latency_stats_p95
`default_nettype wire
